### rtl/i2cm_pkg.sv
// shared types and constants of the i2c master byte engine
`timescale 1ns / 1ps
package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_S_A    = 5'd1,
        PH_S_B    = 5'd2,
        PH_S_C    = 5'd3,
        PH_P_A    = 5'd4,
        PH_P_B    = 5'd5,
        PH_P_C    = 5'd6,
        PH_W_PRE  = 5'd7,
        PH_W_LOW  = 5'd8,
        PH_W_DAT  = 5'd9,
        PH_W_HIGH = 5'd10,
        PH_A_LOW  = 5'd11,
        PH_A_HIGH = 5'd12,
        PH_A_POLL = 5'd13,
        PH_A_TAIL = 5'd14,
        PH_R_PRE  = 5'd15,
        PH_R_LOW  = 5'd16,
        PH_R_HIGH = 5'd17,
        PH_R_SAMP = 5'd18,
        PH_N_LOW  = 5'd19,
        PH_N_HIGH = 5'd20
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  bit_index;
        logic [7:0]  tick_count;
        logic [7:0]  shift_reg;
        logic        read_last;
        logic        ack_flag;
        logic        scl_level;
        logic        sda_level;
        logic        sda_enable;
        logic [7:0]  rx_hold;
    } t_state;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_oe;
        logic        busy_res;
        logic        done_res;
        logic [7:0]  rx_byte;
        logic        ack_ok;
    } t_res;

    typedef struct packed {
        t_state      st;
        logic        done;
    } t_fin;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd100;
    localparam logic [2:0] LAST_BIT        = 3'd7;

    localparam t_state STATE_RST = '{
        phase:      PH_IDLE,
        bit_index:  3'd0,
        tick_count: 8'd0,
        shift_reg:  8'd0,
        read_last:  1'b0,
        ack_flag:   1'b0,
        scl_level:  1'b0,
        sda_level:  1'b1,
        sda_enable: 1'b1,
        rx_hold:    8'd0
    };

endpackage

### rtl/i2cm_if.sv
// handshake channels of the i2c master byte engine
`timescale 1ns / 1ps

interface i2cm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  tx_byte;
    logic        last_read;
    logic        sda_in;
    modport source (output valid, op, tx_byte, last_read, sda_in, input ready);
    modport sink   (input valid, op, tx_byte, last_read, sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic        valid;
    logic        ready;
    logic        scl;
    logic        sda_out;
    logic        sda_oe;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_ok;
    modport source (output valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte, ack_ok,
                    input ready);
    modport sink   (input valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte, ack_ok,
                    output ready);
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/i2cm_step.sv
// next-state and result logic for one tick of the bus sequencer
`timescale 1ns / 1ps
module i2cm_step (
    input  i2cm_pkg::t_state i_cur,
    input  logic [2:0]       i_op,
    input  logic [7:0]       i_tx_byte,
    input  logic             i_last_read,
    input  logic             i_sda_in,
    input  logic [7:0]       i_ack_timeout,
    output i2cm_pkg::t_state o_nxt,
    output i2cm_pkg::t_res   o_res
);
    import i2cm_pkg::*;

    function automatic t_state f_enter(t_state s, t_phase p);
        t_state     r;
        logic [7:0] n;
        r = s;
        n = 8'd1;
        r.phase = p;
        case (p)
            PH_S_A: begin
                r.scl_level = 1'b0; r.sda_level = 1'b1; r.sda_enable = 1'b1;
            end
            PH_S_B: begin
                r.scl_level = 1'b1; n = 8'd2;
            end
            PH_S_C: begin
                r.sda_level = 1'b0; n = 8'd2;
            end
            PH_P_A: begin
                r.scl_level = 1'b0; r.sda_level = 1'b0; r.sda_enable = 1'b1;
            end
            PH_P_B: begin
                r.scl_level = 1'b1; n = 8'd2;
            end
            PH_P_C: begin
                r.sda_level = 1'b1; n = 8'd2;
            end
            PH_W_PRE: begin
                n = 8'd2;
            end
            PH_W_LOW: begin
                r.scl_level = 1'b0;
            end
            PH_W_DAT: begin
                r.sda_level = s.shift_reg[7]; r.sda_enable = 1'b1;
            end
            PH_W_HIGH: begin
                r.scl_level = 1'b1; n = 8'd4;
            end
            PH_A_LOW: begin
                r.scl_level = 1'b0;
            end
            PH_A_HIGH: begin
                r.sda_enable = 1'b0; r.scl_level = 1'b1; n = 8'd2;
            end
            PH_A_POLL: begin
                n = 8'd0;
            end
            PH_A_TAIL: begin
                n = 8'd1;
            end
            PH_R_PRE: begin
                r.scl_level = 1'b0; n = 8'd2;
            end
            PH_R_LOW: begin
                r.scl_level = 1'b0; r.sda_enable = 1'b0;
            end
            PH_R_HIGH: begin
                r.scl_level = 1'b1; n = 8'd2;
            end
            PH_R_SAMP: begin
                n = 8'd1;
            end
            PH_N_LOW: begin
                r.scl_level = 1'b0; r.sda_level = s.read_last; r.sda_enable = 1'b1;
            end
            PH_N_HIGH: begin
                r.scl_level = 1'b1; n = 8'd4;
            end
            default: begin
                r.phase = PH_IDLE; r.scl_level = 1'b0; n = 8'd0;
            end
        endcase
        r.tick_count = n;
        return r;
    endfunction

    function automatic t_fin f_finish(t_state s, logic sda);
        t_fin   f;
        t_state r;
        r = s;
        f.done = 1'b0;
        case (s.phase)
            PH_S_A:   r = f_enter(s, PH_S_B);
            PH_S_B:   r = f_enter(s, PH_S_C);
            PH_P_A:   r = f_enter(s, PH_P_B);
            PH_P_B:   r = f_enter(s, PH_P_C);
            PH_W_PRE: r = f_enter(s, PH_W_LOW);
            PH_W_LOW: r = f_enter(s, PH_W_DAT);
            PH_W_DAT: r = f_enter(s, PH_W_HIGH);
            PH_W_HIGH: begin
                r.shift_reg = {s.shift_reg[6:0], 1'b0};
                if (s.bit_index == LAST_BIT) begin
                    r.bit_index = 3'd0;
                    r = f_enter(r, PH_A_LOW);
                end else begin
                    r.bit_index = s.bit_index + 3'd1;
                    r = f_enter(r, PH_W_LOW);
                end
            end
            PH_A_LOW:  r = f_enter(s, PH_A_HIGH);
            PH_A_HIGH: r = f_enter(s, PH_A_POLL);
            PH_R_PRE:  r = f_enter(s, PH_R_LOW);
            PH_R_LOW:  r = f_enter(s, PH_R_HIGH);
            PH_R_HIGH: begin
                r.shift_reg = {s.shift_reg[6:0], sda};
                r = f_enter(r, PH_R_SAMP);
            end
            PH_R_SAMP: begin
                if (s.bit_index == LAST_BIT) begin
                    r.bit_index = 3'd0;
                    r = f_enter(r, PH_N_LOW);
                end else begin
                    r.bit_index = s.bit_index + 3'd1;
                    r = f_enter(r, PH_R_LOW);
                end
            end
            PH_N_LOW: r = f_enter(s, PH_N_HIGH);
            PH_N_HIGH: begin
                r.rx_hold = s.shift_reg;
                r = f_enter(r, PH_IDLE);
                f.done = 1'b1;
            end
            default: begin
                r = f_enter(s, PH_IDLE);
                f.done = 1'b1;
            end
        endcase
        f.st = r;
        return f;
    endfunction

    t_state v_s;
    t_fin   v_fin;
    logic   v_busy;
    logic   v_done;

    always_comb begin
        v_s    = i_cur;
        v_fin  = '{st: i_cur, done: 1'b0};
        v_done = 1'b0;
        if (v_s.phase == PH_IDLE) begin
            case (i_op)
                OP_START: begin
                    v_s.bit_index = 3'd0;
                    v_s = f_enter(v_s, PH_S_A);
                end
                OP_STOP: begin
                    v_s.bit_index = 3'd0;
                    v_s = f_enter(v_s, PH_P_A);
                end
                OP_WRITE: begin
                    v_s.bit_index = 3'd0;
                    v_s.shift_reg = i_tx_byte;
                    v_s = f_enter(v_s, PH_W_PRE);
                end
                OP_READ: begin
                    v_s.bit_index = 3'd0;
                    v_s.read_last = i_last_read;
                    v_s.shift_reg = 8'd0;
                    v_s = f_enter(v_s, PH_R_PRE);
                end
                default: begin
                    v_s = v_s;
                end
            endcase
        end
        v_busy         = (v_s.phase != PH_IDLE);
        o_res.scl      = v_s.scl_level;
        o_res.sda_out  = v_s.sda_enable & v_s.sda_level;
        o_res.sda_oe   = v_s.sda_enable;
        if (v_busy) begin
            if (v_s.phase == PH_A_POLL) begin
                if (!i_sda_in) begin
                    v_s.ack_flag = 1'b1;
                    v_s = f_enter(v_s, PH_A_TAIL);
                end else if (v_s.tick_count >= i_ack_timeout) begin
                    v_s.ack_flag = 1'b0;
                    v_s = f_enter(v_s, PH_A_TAIL);
                end else begin
                    v_s.tick_count = v_s.tick_count + 8'd1;
                end
            end else begin
                if (v_s.tick_count != 8'd0) begin
                    v_s.tick_count = v_s.tick_count - 8'd1;
                end
                if (v_s.tick_count == 8'd0) begin
                    v_fin  = f_finish(v_s, i_sda_in);
                    v_s    = v_fin.st;
                    v_done = v_fin.done;
                end
            end
        end
        o_res.busy_res = v_busy;
        o_res.done_res = v_done;
        o_res.rx_byte  = v_s.rx_hold;
        o_res.ack_ok   = v_s.ack_flag;
        o_nxt          = v_s;
    end

endmodule

### rtl/i2c_master_byte_engine_unit.sv
// top level of the i2c master byte engine
`timescale 1ns / 1ps
// One command transaction is one bus tick and yields exactly one result transaction that
// describes that tick (line levels, busy, done, last received byte, last acknowledge).
// The engine takes a transaction every clock cycle unless the result side stalls: sequencer
// state and result register load when one is taken, so its result shows in the cycle after,
// and a new one is taken whenever the result register is empty or being drained. Ops other
// than start, stop, write and read, and any op that arrives while a command is running, only
// advance the bus timing. The user must write the ack_timeout register through the configuration
// channel only while the engine is idle, which the engine does not enforce; it resets to 100.
module i2c_master_byte_engine_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    i2cm_cmd_if.sink   i_cmd,
    i2cm_cfg_if.sink   i_cfg,
    i2cm_res_if.source o_res
);
    import i2cm_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_ack_timeout;
    logic       r_out_valid;
    t_res       r_res;
    t_res       n_res;
    logic       w_take;

    i2cm_step u_step (
        .i_cur         (r_state),
        .i_op          (i_cmd.op),
        .i_tx_byte     (i_cmd.tx_byte),
        .i_last_read   (i_cmd.last_read),
        .i_sda_in      (i_cmd.sda_in),
        .i_ack_timeout (r_ack_timeout),
        .o_nxt         (n_state),
        .o_res         (n_res)
    );

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= STATE_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_ack_timeout <= i_cfg.data;
            end
            if (w_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.scl      = r_res.scl;
    assign o_res.sda_out  = r_res.sda_out;
    assign o_res.sda_oe   = r_res.sda_oe;
    assign o_res.busy_res = r_res.busy_res;
    assign o_res.done_res = r_res.done_res;
    assign o_res.rx_byte  = r_res.rx_byte;
    assign o_res.ack_ok   = r_res.ack_ok;

endmodule

### rtl/i2cm_checker.sv
// port-level checks of the i2c master byte engine and their bind
`timescale 1ns / 1ps
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_scl,
    input logic       i_sda_out,
    input logic       i_sda_oe,
    input logic       i_busy_res,
    input logic       i_done_res
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_sda_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_sda_oe |-> !i_sda_out)
        else $error("sda_out high while sda released");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done_res |-> i_busy_res)
        else $error("done without busy");

    a_idle_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_busy_res |-> !i_scl)
        else $error("scl high while idle");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_scl       (o_res.scl),
    .i_sda_out   (o_res.sda_out),
    .i_sda_oe    (o_res.sda_oe),
    .i_busy_res  (o_res.busy_res),
    .i_done_res  (o_res.done_res)
);

### bench/i2cm_tick_checker.sv
// checker that predicts each bus tick of the i2c master byte engine and compares results
`timescale 1ns / 1ps
module i2cm_tick_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    i2cm_cmd_if  cmd,
    i2cm_cfg_if  cfg,
    i2cm_res_if  res,
    output int   o_errors,
    output int   o_pending
);
    import i2cm_pkg::*;

    t_phase     ph;
    logic [2:0] bidx;
    logic [7:0] tcnt;
    logic [7:0] shreg;
    logic [7:0] rxh;
    logic [7:0] tmo;
    logic       rdlast;
    logic       ackf;
    logic       sclv;
    logic       sdav;
    logic       sdae;

    t_res expected_ticks[$];
    t_res seen;
    t_res want;
    int   mism = 0;
    int   ticks_checked = 0;

    function automatic void go(input t_phase p);
        logic [7:0] n;
        n  = 8'd1;
        ph = p;
        case (p)
            PH_S_A: begin
                sclv = 1'b0; sdav = 1'b1; sdae = 1'b1;
            end
            PH_S_B: begin
                sclv = 1'b1; n = 8'd2;
            end
            PH_S_C: begin
                sdav = 1'b0; n = 8'd2;
            end
            PH_P_A: begin
                sclv = 1'b0; sdav = 1'b0; sdae = 1'b1;
            end
            PH_P_B: begin
                sclv = 1'b1; n = 8'd2;
            end
            PH_P_C: begin
                sdav = 1'b1; n = 8'd2;
            end
            PH_W_PRE: n = 8'd2;
            PH_W_LOW: sclv = 1'b0;
            PH_W_DAT: begin
                sdav = shreg[7]; sdae = 1'b1;
            end
            PH_W_HIGH: begin
                sclv = 1'b1; n = 8'd4;
            end
            PH_A_LOW: sclv = 1'b0;
            PH_A_HIGH: begin
                sdae = 1'b0; sclv = 1'b1; n = 8'd2;
            end
            PH_A_POLL: n = 8'd0;
            PH_A_TAIL, PH_R_SAMP: ;
            PH_R_PRE: begin
                sclv = 1'b0; n = 8'd2;
            end
            PH_R_LOW: begin
                sclv = 1'b0; sdae = 1'b0;
            end
            PH_R_HIGH: begin
                sclv = 1'b1; n = 8'd2;
            end
            PH_N_LOW: begin
                sclv = 1'b0; sdav = rdlast; sdae = 1'b1;
            end
            PH_N_HIGH: begin
                sclv = 1'b1; n = 8'd4;
            end
            default: begin
                ph = PH_IDLE; sclv = 1'b0; n = 8'd0;
            end
        endcase
        tcnt = n;
    endfunction

    // end of a timed phase, returns 1 when the command completes
    function automatic logic phase_end(input logic sda);
        logic fin;
        fin = 1'b0;
        case (ph)
            PH_S_A:   go(PH_S_B);
            PH_S_B:   go(PH_S_C);
            PH_P_A:   go(PH_P_B);
            PH_P_B:   go(PH_P_C);
            PH_W_PRE: go(PH_W_LOW);
            PH_W_LOW: go(PH_W_DAT);
            PH_W_DAT: go(PH_W_HIGH);
            PH_W_HIGH: begin
                shreg = {shreg[6:0], 1'b0};
                if (bidx >= LAST_BIT) begin
                    bidx = 3'd0;
                    go(PH_A_LOW);
                end else begin
                    bidx = bidx + 3'd1;
                    go(PH_W_LOW);
                end
            end
            PH_A_LOW:  go(PH_A_HIGH);
            PH_A_HIGH: go(PH_A_POLL);
            PH_R_PRE:  go(PH_R_LOW);
            PH_R_LOW:  go(PH_R_HIGH);
            PH_R_HIGH: begin
                shreg = {shreg[6:0], sda};
                go(PH_R_SAMP);
            end
            PH_R_SAMP: begin
                if (bidx >= LAST_BIT) begin
                    bidx = 3'd0;
                    go(PH_N_LOW);
                end else begin
                    bidx = bidx + 3'd1;
                    go(PH_R_LOW);
                end
            end
            PH_N_LOW: go(PH_N_HIGH);
            PH_N_HIGH: begin
                rxh = shreg;
                go(PH_IDLE);
                fin = 1'b1;
            end
            default: begin
                go(PH_IDLE);
                fin = 1'b1;
            end
        endcase
        return fin;
    endfunction

    function automatic t_res next_tick(input logic [2:0] op, input logic [7:0] txb,
                                       input logic lastr, input logic sda);
        t_res r;
        logic busy;
        logic done;
        done = 1'b0;
        if (ph == PH_IDLE && op >= OP_START && op <= OP_READ) begin
            bidx = 3'd0;
            case (op)
                OP_START: go(PH_S_A);
                OP_STOP:  go(PH_P_A);
                OP_WRITE: begin
                    shreg = txb;
                    go(PH_W_PRE);
                end
                default: begin
                    rdlast = lastr;
                    shreg  = 8'd0;
                    go(PH_R_PRE);
                end
            endcase
        end
        busy      = (ph != PH_IDLE);
        r.scl     = sclv;
        r.sda_out = sdae & sdav;
        r.sda_oe  = sdae;
        if (busy) begin
            if (ph == PH_A_POLL) begin
                if (!sda) begin
                    ackf = 1'b1;
                    go(PH_A_TAIL);
                end else if (tcnt >= tmo) begin
                    ackf = 1'b0;
                    go(PH_A_TAIL);
                end else begin
                    tcnt = tcnt + 8'd1;
                end
            end else begin
                if (tcnt > 8'd0) tcnt = tcnt - 8'd1;
                if (tcnt == 8'd0) done = phase_end(sda);
            end
        end
        r.busy_res = busy;
        r.done_res = done;
        r.rx_byte  = rxh;
        r.ack_ok   = ackf;
        return r;
    endfunction

    task automatic flag_field(input string fname, input logic [7:0] want_v,
                              input logic [7:0] seen_v);
        if (seen_v !== want_v) begin
            if (mism < 10)
                $display("tick %0d: %s expected %0h got %0h", ticks_checked, fname,
                         want_v, seen_v);
            mism++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph     = STATE_RST.phase;
            bidx   = STATE_RST.bit_index;
            tcnt   = STATE_RST.tick_count;
            shreg  = STATE_RST.shift_reg;
            rdlast = STATE_RST.read_last;
            ackf   = STATE_RST.ack_flag;
            sclv   = STATE_RST.scl_level;
            sdav   = STATE_RST.sda_level;
            sdae   = STATE_RST.sda_enable;
            rxh    = STATE_RST.rx_hold;
            tmo    = ACK_TIMEOUT_RST;
            expected_ticks.delete();
        end else begin
            if (res.valid && res.ready) begin
                seen.scl      = res.scl;
                seen.sda_out  = res.sda_out;
                seen.sda_oe   = res.sda_oe;
                seen.busy_res = res.busy_res;
                seen.done_res = res.done_res;
                seen.rx_byte  = res.rx_byte;
                seen.ack_ok   = res.ack_ok;
                if (expected_ticks.size() == 0) begin
                    if (mism < 10) $display("tick %0d: result with nothing pending", ticks_checked);
                    mism++;
                end else begin
                    want = expected_ticks.pop_front();
                    flag_field("scl", want.scl, seen.scl);
                    flag_field("sda_out", want.sda_out, seen.sda_out);
                    flag_field("sda_oe", want.sda_oe, seen.sda_oe);
                    flag_field("busy", want.busy_res, seen.busy_res);
                    flag_field("done", want.done_res, seen.done_res);
                    flag_field("rx_byte", want.rx_byte, seen.rx_byte);
                    flag_field("ack_ok", want.ack_ok, seen.ack_ok);
                end
                ticks_checked++;
            end
            if (cmd.valid && cmd.ready)
                expected_ticks.push_back(next_tick(cmd.op, cmd.tx_byte, cmd.last_read,
                                                   cmd.sda_in));
            if (cfg.valid && cfg.ready) tmo = cfg.data;
        end
        o_pending = expected_ticks.size();
        o_errors  = mism;
    end

endmodule

### bench/testbench.sv
// top of the i2c master byte engine bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import i2cm_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_LEN     = 150;
    localparam int PHASE_ITEMS  = 160;
    localparam int SDA_RANDOM      = 0;
    localparam int SDA_HIGH        = 1;
    localparam int SDA_MOSTLY_HIGH = 2;
    localparam int SDA_LOW         = 3;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    i2cm_cmd_if cmd_ch();
    i2cm_cfg_if cfg_ch();
    i2cm_res_if res_ch();

    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    bit   hold_armed   = 1'b0;
    bit   hold_spent   = 1'b0;
    int   ticks_sent   = 0;
    int   ticks_seen   = 0;
    int   cmds_done    = 0;
    logic bus_idle     = 1'b1;
    int   quiet_cycles = 0;
    int   errors;
    int   pending;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    i2c_master_byte_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    i2cm_tick_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cmd       (cmd_ch),
        .cfg       (cfg_ch),
        .res       (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ticks_seen <= 0;
            cmds_done  <= 0;
            bus_idle   <= 1'b1;
        end else if (res_ch.valid && res_ch.ready) begin
            ticks_seen <= ticks_seen + 1;
            bus_idle   <= !res_ch.busy_res || res_ch.done_res;
            if (res_ch.done_res) cmds_done <= cmds_done + 1;
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side, with one long hold-off to back up the engine
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_armed && !hold_spent) begin
                hold_spent = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic logic pick_sda(input int mode);
        case (mode)
            SDA_HIGH:        return 1'b1;
            SDA_MOSTLY_HIGH: return ($urandom_range(9) != 0);
            SDA_LOW:         return 1'b0;
            default:         return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [7:0] txb, input logic lastr,
                             input logic sda);
        while ($urandom_range(99) < snd_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.op        <= op;
        cmd_ch.tx_byte   <= txb;
        cmd_ch.last_read <= lastr;
        cmd_ch.sda_in    <= sda;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // issue one command and tick until it completes, optionally poking more commands at it
    task automatic run_command(input t_op op, input logic [7:0] txb, input logic lastr,
                               input int sda_mode, input int pokes);
        int d0;
        int k;
        d0 = cmds_done;
        k  = 0;
        send_item(op, txb, lastr, pick_sda(sda_mode));
        while (cmds_done == d0) begin
            if (k < pokes)
                send_item(3'($urandom_range(OP_READ, OP_START)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), pick_sda(sda_mode));
            else
                send_item(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          pick_sda(sda_mode));
            k++;
        end
    endtask

    task automatic settle_bus();
        forever begin
            cmd_ch.valid <= 1'b0;
            do @(posedge i_clk); while (ticks_seen != ticks_sent);
            if (bus_idle) break;
            send_item(OP_TICK, 8'd0, 1'b0, 1'($urandom_range(1)));
        end
    endtask

    task automatic set_ack_timeout(input logic [7:0] value);
        repeat (2) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n, input bit with_hold);
        int k;
        int r;
        int sda_mode;
        logic [2:0] op;
        sda_mode = SDA_RANDOM;
        for (k = 0; k < n; k++) begin
            if (k % 40 == 0) sda_mode = $urandom_range(SDA_MOSTLY_HIGH, SDA_RANDOM);
            if (with_hold && k == n / 3) hold_armed = 1'b1;
            r = $urandom_range(99);
            if (r < 12)
                op = 3'($urandom_range(OP_READ, OP_START));
            else if (r < 20)
                op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            else
                op = OP_TICK;
            send_item(op, 8'($urandom_range(255)), 1'($urandom_range(1)), pick_sda(sda_mode));
        end
    endtask

    initial begin
        int k;
        cmd_ch.valid     = 1'b0;
        cmd_ch.op        = OP_TICK;
        cmd_ch.tx_byte   = 8'd0;
        cmd_ch.last_read = 1'b0;
        cmd_ch.sda_in    = 1'b1;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = 8'd0;
        snd_idle_pct     = 21;
        rcv_idle_pct     = 67;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
            send_item(k[2:0], 8'hFF, 1'b1, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b1);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
        run_command(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);
        run_command(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 3);
        run_command(OP_READ, 8'h00, 1'b0, SDA_HIGH, 0);
        run_command(OP_READ, 8'hFF, 1'b1, SDA_LOW, 3);
        run_command(OP_READ, 8'h5A, 1'b1, SDA_RANDOM, 0);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

        for (k = 0; k < 3; k++) begin
            settle_bus();
            case (k)
                0: begin
                    set_ack_timeout(8'd0);
                    snd_idle_pct = 21;
                    rcv_idle_pct = 67;
                end
                1: begin
                    set_ack_timeout(8'd255);
                    snd_idle_pct = 67;
                    rcv_idle_pct = 21;
                end
                default: begin
                    set_ack_timeout(8'($urandom_range(254, 1)));
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            random_traffic(PHASE_ITEMS, k == 2);
        end

        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (ticks_seen != ticks_sent);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
